### rtl/u8d_pkg.sv
package u8d_pkg;

  localparam int unsigned COUNT_BITS = 16;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned REM_W   = 2;
  localparam int unsigned CNT_EXT_W = (COUNT_BITS > CNT_W) ? COUNT_BITS : CNT_W;

  localparam logic [BYTE_W-1:0] BYTE_NUL  = 8'h00;
  localparam logic [BYTE_W-1:0] LEAD2_LO  = 8'hc2;
  localparam logic [BYTE_W-1:0] LEAD2_HI  = 8'hdf;
  localparam logic [BYTE_W-1:0] LEAD3_LO  = 8'he0;
  localparam logic [BYTE_W-1:0] LEAD3_HI  = 8'hef;
  localparam logic [BYTE_W-1:0] LEAD4_LO  = 8'hf0;
  localparam logic [BYTE_W-1:0] LEAD4_HI  = 8'hf4;
  localparam logic [BYTE_W-1:0] MASK_L2   = 8'h1f;
  localparam logic [BYTE_W-1:0] MASK_L3   = 8'h0f;
  localparam logic [BYTE_W-1:0] MASK_L4   = 8'h07;
  localparam logic [BYTE_W-1:0] MASK_CONT = 8'h3f;

  localparam logic [REM_W-1:0] REM_NONE = 2'd0;
  localparam logic [REM_W-1:0] REM_ONE  = 2'd1;
  localparam logic [REM_W-1:0] REM_TWO  = 2'd2;
  localparam logic [REM_W-1:0] REM_THREE = 2'd3;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic             char_valid;
    logic             truncated;
    logic             string_end;
    logic [CNT_W-1:0] char_count;
  } result_t;

  // Per-cycle control from the decode core to the stage registers
  typedef struct packed {
    logic consume;
    logic has_result;
  } step_t;

endpackage

### rtl/u8d_if.sv
interface u8d_byte_if;
  logic                        valid;
  logic                        ready;
  logic [u8d_pkg::BYTE_W-1:0]  in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8d_result_if;
  logic                        valid;
  logic                        ready;
  logic [u8d_pkg::CP_W-1:0]    code_point;
  logic                        char_valid;
  logic                        truncated;
  logic                        string_end;
  logic [u8d_pkg::CNT_W-1:0]   char_count;

  modport source (output valid, output code_point, output char_valid, output truncated,
                  output string_end, output char_count, input ready);
  modport sink   (input valid, input code_point, input char_valid, input truncated,
                  input string_end, input char_count, output ready);
endinterface

### rtl/utf8_to_codepoint_decoder_top.sv
// Channel  | Dir | Payload                                                | Transfer
// ---------+-----+--------------------------------------------------------+------------------
// in_i     | in  | in_byte[7:0]                                           | valid && ready
// out_o    | out | code_point[20:0] char_valid truncated string_end       | valid && ready
//          |     | char_count[15:0]                                       |
//
// One byte per cycle sustained while out_o takes its results; the decode is a single shift-or and a counter step.
// A result is offered on out_o from the result register; its byte passes the input
// register, then the decode, which loads the result register when it is free.
// Lead bytes and non-final continuations produce no result transfer.
// Reset clears the sequence state, the character count and both valid flags.
// A stall on out_o holds the result register; input keeps flowing while the held
// byte needs no result slot.
module utf8_to_codepoint_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  u8d_byte_if.sink           in_i,
  u8d_result_if.source       out_o
);

  logic                       s1_valid;
  logic [u8d_pkg::BYTE_W-1:0] s1_byte;
  logic                       out_free;
  u8d_pkg::step_t             step;
  u8d_pkg::result_t           core_result;
  u8d_pkg::result_t           held_result;

  // Input register: hold one byte ahead of the decode
  u8d_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .byte_i  (in_i.in_byte),
    .ready_o (in_i.ready),
    .step_i  (step),
    .valid_o (s1_valid),
    .byte_o  (s1_byte)
  );

  // Decode core: advance sequence state and form the result
  u8d_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_valid),
    .byte_i     (s1_byte),
    .out_free_i (out_free),
    .step_o     (step),
    .result_o   (core_result)
  );

  // Result register: hold the result until the sink takes it
  u8d_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .result_i (core_result),
    .free_o   (out_free),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .result_o (held_result)
  );

  assign out_o.code_point = held_result.code_point;
  assign out_o.char_valid = held_result.char_valid;
  assign out_o.truncated  = held_result.truncated;
  assign out_o.string_end = held_result.string_end;
  assign out_o.char_count = held_result.char_count;

endmodule

### rtl/u8d_in_reg.sv
module u8d_in_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [u8d_pkg::BYTE_W-1:0] byte_i,
  output logic                       ready_o,
  input  u8d_pkg::step_t             step_i,
  output logic                       valid_o,
  output logic [u8d_pkg::BYTE_W-1:0] byte_o
);

  logic                       valid_q, valid_d;
  logic [u8d_pkg::BYTE_W-1:0] byte_q;

  // Take a new byte when empty or when the held one drains this cycle
  assign ready_o = !valid_q || step_i.consume;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

### rtl/u8d_core.sv
module u8d_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [u8d_pkg::BYTE_W-1:0] byte_i,
  input  logic                       out_free_i,
  output u8d_pkg::step_t             step_o,
  output u8d_pkg::result_t           result_o
);

  localparam logic [u8d_pkg::COUNT_BITS-1:0] CountMax = '1;
  localparam logic [u8d_pkg::CNT_EXT_W-1:0]  FieldMax =
      u8d_pkg::CNT_EXT_W'({u8d_pkg::CNT_W{1'b1}});

  logic [u8d_pkg::REM_W-1:0]      rem_q, rem_d;
  logic [u8d_pkg::CP_W-1:0]       acc_q, acc_d;
  logic [u8d_pkg::COUNT_BITS-1:0] cnt_q, cnt_d;

  logic [u8d_pkg::COUNT_BITS-1:0] cnt_inc;
  logic [u8d_pkg::COUNT_BITS-1:0] cnt_rep;
  logic [u8d_pkg::CNT_EXT_W-1:0]  cnt_ext;
  logic [u8d_pkg::CP_W-1:0]       acc_shift;
  logic                           has_result;
  logic                           consume;
  logic                           trunc;

  assign cnt_inc   = (cnt_q == CountMax) ? cnt_q : cnt_q + u8d_pkg::COUNT_BITS'(1);
  assign acc_shift = {acc_q[u8d_pkg::CP_W-7:0], byte_i[5:0]};
  assign trunc     = (rem_q != u8d_pkg::REM_NONE);
  assign cnt_rep   = trunc ? cnt_inc : cnt_q;
  assign cnt_ext   = u8d_pkg::CNT_EXT_W'(cnt_rep);

  always_comb begin
    rem_d      = rem_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    has_result = 1'b0;
    result_o   = '0;
    if (byte_i == u8d_pkg::BYTE_NUL) begin
      // Terminator: report, flush any partial character, clear for next string
      has_result          = 1'b1;
      result_o.string_end = 1'b1;
      result_o.char_valid = trunc;
      result_o.truncated  = trunc;
      result_o.code_point = trunc ? acc_q : '0;
      result_o.char_count = (cnt_ext > FieldMax) ? u8d_pkg::CNT_W'(FieldMax)
                                                 : cnt_ext[u8d_pkg::CNT_W-1:0];
      rem_d = u8d_pkg::REM_NONE;
      acc_d = '0;
      cnt_d = '0;
    end else if (trunc) begin
      rem_d = rem_q - u8d_pkg::REM_ONE;
      acc_d = acc_shift;
      if (rem_q == u8d_pkg::REM_ONE) begin
        has_result          = 1'b1;
        result_o.char_valid = 1'b1;
        result_o.code_point = acc_shift;
        acc_d = '0;
        cnt_d = cnt_inc;
      end
    end else if (byte_i >= u8d_pkg::LEAD2_LO && byte_i <= u8d_pkg::LEAD2_HI) begin
      rem_d = u8d_pkg::REM_ONE;
      acc_d = u8d_pkg::CP_W'(byte_i & u8d_pkg::MASK_L2);
    end else if (byte_i >= u8d_pkg::LEAD3_LO && byte_i <= u8d_pkg::LEAD3_HI) begin
      rem_d = u8d_pkg::REM_TWO;
      acc_d = u8d_pkg::CP_W'(byte_i & u8d_pkg::MASK_L3);
    end else if (byte_i >= u8d_pkg::LEAD4_LO && byte_i <= u8d_pkg::LEAD4_HI) begin
      rem_d = u8d_pkg::REM_THREE;
      acc_d = u8d_pkg::CP_W'(byte_i & u8d_pkg::MASK_L4);
    end else begin
      // ASCII or stray byte passes through as its own code point
      has_result          = 1'b1;
      result_o.char_valid = 1'b1;
      result_o.code_point = u8d_pkg::CP_W'(byte_i);
      cnt_d = cnt_inc;
    end
  end

  // Drain a byte unless it needs the result register and that is still full
  assign consume = valid_i && (!has_result || out_free_i);
  assign step_o.consume    = consume;
  assign step_o.has_result = has_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= u8d_pkg::REM_NONE;
      acc_q <= '0;
      cnt_q <= '0;
    end else if (consume) begin
      rem_q <= rem_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
      consume && byte_i == u8d_pkg::BYTE_NUL |=> rem_q == u8d_pkg::REM_NONE && cnt_q == '0)
    else $error("state not cleared after terminator");
  a_nul_reports : assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid_i && byte_i == u8d_pkg::BYTE_NUL |-> has_result && result_o.string_end)
    else $error("terminator without end result");
  a_last_cont : assert property (@(posedge clk_i) disable iff (!rst_ni)
      consume && rem_q == u8d_pkg::REM_ONE && byte_i != u8d_pkg::BYTE_NUL
      |-> has_result && result_o.char_valid && !result_o.string_end)
    else $error("final continuation gave no character");
  a_trunc_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
      has_result && result_o.truncated |-> result_o.char_valid && result_o.string_end)
    else $error("truncated flag without character at end");
`endif

endmodule

### rtl/u8d_out_reg.sv
module u8d_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  u8d_pkg::step_t   step_i,
  input  u8d_pkg::result_t result_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             ready_i,
  output u8d_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  logic             load;
  u8d_pkg::result_t result_q;

  assign free_o  = !valid_q || ready_i;
  assign load    = step_i.consume && step_i.has_result;
  assign valid_d = load || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

### sim/u8d_checker.sv
`timescale 1ns / 1ps
module u8d_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       byte_valid_i,
  input  logic                       byte_ready_i,
  input  logic [u8d_pkg::BYTE_W-1:0] byte_i,
  input  logic                       res_valid_i,
  input  logic                       res_ready_i,
  input  u8d_pkg::result_t           res_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o,
  output int unsigned                chars_seen_o,
  output int unsigned                strings_seen_o,
  output int unsigned                truncated_seen_o
);

  localparam longint unsigned COUNT_MAX = (64'd1 << u8d_pkg::COUNT_BITS) - 64'd1;
  localparam longint unsigned FIELD_MAX = (64'd1 << u8d_pkg::CNT_W) - 64'd1;

  logic [u8d_pkg::REM_W-1:0] seq_left;
  logic [u8d_pkg::CP_W-1:0]  partial_cp;
  longint unsigned           char_total;
  u8d_pkg::result_t          pending_chars[$];

  task automatic flag(input string msg);
    $display("%0t: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic count_char();
    if (char_total < COUNT_MAX) char_total++;
  endtask

  // Advance the decoder state by one byte; queue the result it causes, if any
  task automatic decode_byte(input logic [u8d_pkg::BYTE_W-1:0] b);
    u8d_pkg::result_t r;
    r = '0;
    if (b == u8d_pkg::BYTE_NUL) begin
      if (seq_left != u8d_pkg::REM_NONE) begin
        count_char();
        r.code_point = partial_cp;
        r.char_valid = 1'b1;
        r.truncated  = 1'b1;
      end
      r.string_end = 1'b1;
      r.char_count = (char_total > FIELD_MAX) ? u8d_pkg::CNT_W'(FIELD_MAX)
                                              : u8d_pkg::CNT_W'(char_total);
      pending_chars.push_back(r);
      seq_left   = u8d_pkg::REM_NONE;
      partial_cp = '0;
      char_total = 0;
    end else if (seq_left != u8d_pkg::REM_NONE) begin
      partial_cp = (partial_cp << 6) | u8d_pkg::CP_W'(b & u8d_pkg::MASK_CONT);
      seq_left   = seq_left - u8d_pkg::REM_ONE;
      if (seq_left == u8d_pkg::REM_NONE) begin
        count_char();
        r.code_point = partial_cp;
        r.char_valid = 1'b1;
        pending_chars.push_back(r);
        partial_cp = '0;
      end
    end else if (b >= u8d_pkg::LEAD2_LO && b <= u8d_pkg::LEAD2_HI) begin
      partial_cp = u8d_pkg::CP_W'(b & u8d_pkg::MASK_L2);
      seq_left   = u8d_pkg::REM_ONE;
    end else if (b >= u8d_pkg::LEAD3_LO && b <= u8d_pkg::LEAD3_HI) begin
      partial_cp = u8d_pkg::CP_W'(b & u8d_pkg::MASK_L3);
      seq_left   = u8d_pkg::REM_TWO;
    end else if (b >= u8d_pkg::LEAD4_LO && b <= u8d_pkg::LEAD4_HI) begin
      partial_cp = u8d_pkg::CP_W'(b & u8d_pkg::MASK_L4);
      seq_left   = u8d_pkg::REM_THREE;
    end else begin
      count_char();
      r.code_point = u8d_pkg::CP_W'(b);
      r.char_valid = 1'b1;
      pending_chars.push_back(r);
    end
  endtask

  task automatic check_result(input u8d_pkg::result_t got);
    u8d_pkg::result_t want;
    if (got.char_valid) chars_seen_o++;
    if (got.string_end) strings_seen_o++;
    if (got.truncated) truncated_seen_o++;
    if (pending_chars.size() == 0) begin
      flag($sformatf("unexpected result: expected none, got %p", got));
      return;
    end
    want = pending_chars.pop_front();
    if (got.code_point !== want.code_point)
      flag($sformatf("code_point mismatch: expected %h, got %h",
                     want.code_point, got.code_point));
    if (got.char_valid !== want.char_valid)
      flag($sformatf("char_valid mismatch: expected %b, got %b",
                     want.char_valid, got.char_valid));
    if (got.truncated !== want.truncated)
      flag($sformatf("truncated mismatch: expected %b, got %b",
                     want.truncated, got.truncated));
    if (got.string_end !== want.string_end)
      flag($sformatf("string_end mismatch: expected %b, got %b",
                     want.string_end, got.string_end));
    if (got.char_count !== want.char_count)
      flag($sformatf("char_count mismatch: expected %0d, got %0d",
                     want.char_count, got.char_count));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_left         = u8d_pkg::REM_NONE;
      partial_cp       = '0;
      char_total       = 0;
      pending_chars.delete();
      fail_count_o     = 0;
      pending_o        = 0;
      chars_seen_o     = 0;
      strings_seen_o   = 0;
      truncated_seen_o = 0;
    end else begin
      // Predict first so a result transferred together with its byte would still find its entry
      if (byte_valid_i && byte_ready_i) decode_byte(byte_i);
      if (res_valid_i && res_ready_i) check_result(res_i);
      pending_o = pending_chars.size();
    end
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;

  // Generous bound for a correct run under the heaviest stall profiles
  localparam int unsigned CYCLE_LIMIT  = 50_000;
  localparam int unsigned BYTES_TARGET = 950;
  localparam int unsigned HOLD_RESERVE = 80;
  localparam int unsigned HOLD_CYCLES  = 300;

  localparam logic [u8d_pkg::BYTE_W-1:0] ASCII_HI = 8'h7f;
  localparam logic [u8d_pkg::BYTE_W-1:0] STRAY_LO = 8'h80;
  localparam logic [u8d_pkg::BYTE_W-1:0] BYTE_MAX = 8'hff;

  typedef enum {CH_ASCII, CH_STRAY, CH_TWO, CH_THREE, CH_FOUR} char_kind_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic in_took;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned bytes_sent    = 0;
  int unsigned strings_sent  = 0;
  int unsigned cycle_cnt     = 0;

  int unsigned fail_count, pending, chars_seen, strings_seen, truncated_seen;

  u8d_byte_if   in_if ();
  u8d_result_if out_if ();

  always #4 clk_i = ~clk_i;

  utf8_to_codepoint_decoder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  u8d_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .byte_valid_i     (in_if.valid),
    .byte_ready_i     (in_if.ready),
    .byte_i           (in_if.in_byte),
    .res_valid_i      (out_if.valid),
    .res_ready_i      (out_if.ready),
    .res_i            ({out_if.code_point, out_if.char_valid, out_if.truncated,
                        out_if.string_end, out_if.char_count}),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .chars_seen_o     (chars_seen),
    .strings_seen_o   (strings_seen),
    .truncated_seen_o (truncated_seen)
  );

  // Register each input transfer so the driver can read it at the falling edge
  always @(posedge clk_i) in_took <= in_if.valid && in_if.ready;

  // Result sink: random stalls, or a long hold-off counted down here
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // Watchdog: end the run if the traffic never drains
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycle_cnt, pending);
    $display("testbench: FAIL");
    $finish;
  end

  // Offer one byte, idling first at the current rate; return after its transfer
  task automatic send_byte(input logic [u8d_pkg::BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    do @(negedge clk_i); while (in_took !== 1'b1);
    bytes_sent++;
    if (b == u8d_pkg::BYTE_NUL) strings_sent++;
  endtask

  // Mostly proper continuations, sometimes any nonzero byte (taken unchecked)
  function automatic logic [u8d_pkg::BYTE_W-1:0] cont_byte();
    if ($urandom_range(0, 4) != 0)
      return STRAY_LO | u8d_pkg::BYTE_W'($urandom_range(0, 63));
    return u8d_pkg::BYTE_W'($urandom_range(1, 255));
  endfunction

  function automatic char_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return CH_ASCII;
    if (r < 50) return CH_STRAY;
    if (r < 70) return CH_TWO;
    if (r < 85) return CH_THREE;
    return CH_FOUR;
  endfunction

  // Send one character; with cut set, drop at least one continuation
  task automatic send_char(input char_kind_e kind, input bit cut);
    logic [u8d_pkg::BYTE_W-1:0] lead;
    int unsigned                n_cont;
    n_cont = 0;
    case (kind)
      CH_ASCII: lead = u8d_pkg::BYTE_W'($urandom_range(1, ASCII_HI));
      CH_STRAY: begin
        if ($urandom_range(0, 1) != 0)
          lead = u8d_pkg::BYTE_W'($urandom_range(STRAY_LO, u8d_pkg::LEAD2_LO - 1));
        else
          lead = u8d_pkg::BYTE_W'($urandom_range(u8d_pkg::LEAD4_HI + 1, BYTE_MAX));
      end
      CH_TWO: begin
        lead   = u8d_pkg::BYTE_W'($urandom_range(u8d_pkg::LEAD2_LO, u8d_pkg::LEAD2_HI));
        n_cont = 1;
      end
      CH_THREE: begin
        lead   = u8d_pkg::BYTE_W'($urandom_range(u8d_pkg::LEAD3_LO, u8d_pkg::LEAD3_HI));
        n_cont = 2;
      end
      default: begin
        lead   = u8d_pkg::BYTE_W'($urandom_range(u8d_pkg::LEAD4_LO, u8d_pkg::LEAD4_HI));
        n_cont = 3;
      end
    endcase
    if (cut && n_cont > 0) n_cont = $urandom_range(0, n_cont - 1);
    send_byte(lead);
    repeat (n_cont) send_byte(cont_byte());
  endtask

  task automatic send_string(input int unsigned n_chars, input bit cut_last);
    repeat (n_chars) send_char(pick_kind(), 1'b0);
    if (cut_last) send_char(char_kind_e'($urandom_range(CH_TWO, CH_FOUR)), 1'b1);
    send_byte(u8d_pkg::BYTE_NUL);
  endtask

  // Mostly well-formed strings with random content, the rest raw byte noise
  task automatic random_traffic(input int unsigned upto);
    while (bytes_sent < upto) begin
      if ($urandom_range(0, 99) < 85) begin
        send_string($urandom_range(0, 10), $urandom_range(0, 5) == 0);
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(u8d_pkg::BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // Directed bytes: empty string, ASCII and stray extremes, 2-byte leads at
  // both edges, top 3-/4-byte leads, unchecked continuations, NUL mid-sequence
  logic [u8d_pkg::BYTE_W-1:0] directed_bytes[] = '{
    8'h00,
    8'h01, 8'h7f, 8'h80, 8'hff, 8'hc1, 8'hf5, 8'h00,
    8'hc2, 8'h80, 8'hdf, 8'hbf,
    8'hef, 8'hbf, 8'hbf,
    8'hf4, 8'hbf, 8'hbf, 8'hbf,
    8'he1, 8'h01, 8'hfe, 8'h00,
    8'hf4, 8'h8f, 8'h00
  };

  initial begin
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Slow sender, heavily stalled receiver
    src_idle_pct  = 17;
    sink_idle_pct = 84;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    random_traffic(BYTES_TARGET / 3);

    // Bursty sink, sparse sender
    src_idle_pct  = 84;
    sink_idle_pct = 17;
    random_traffic(2 * BYTES_TARGET / 3);

    // Full rate in both directions
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    random_traffic(BYTES_TARGET - HOLD_RESERVE);

    // Hold off the sink while bytes keep coming so the input side backs up
    @(posedge clk_i);
    hold_left = HOLD_CYCLES;
    @(negedge clk_i);
    send_string(40, 1'b0);

    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("covered %0d bytes in %0d strings under three stall profiles and a %0d-cycle",
             bytes_sent, strings_sent, HOLD_CYCLES);
    $display("sink hold-off; %0d characters, %0d string ends, %0d truncated seen",
             chars_seen, strings_seen, truncated_seen);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
